// File: hdl/dial_string_filter_assert.svh
// Assertion macros for the dial string filter.
`ifndef DIAL_STRING_FILTER_ASSERT_SVH
`define DIAL_STRING_FILTER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define DSF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define DSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/dsf_pkg.sv
package dsf_pkg;

	// Character codes
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_UP_I  = 8'h49;
	localparam logic [7:0] CH_LO_I  = 8'h69;
	localparam logic [7:0] CH_UP_G  = 8'h47;
	localparam logic [7:0] CH_LO_G  = 8'h67;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_UP_C  = 8'h43;
	localparam logic [7:0] CH_LO_C  = 8'h63;
	localparam logic [7:0] CH_UP_T  = 8'h54;
	localparam logic [7:0] CH_LO_T  = 8'h74;
	localparam logic [7:0] CH_UP_D  = 8'h44;
	localparam logic [7:0] CH_LO_D  = 8'h64;

	// Byte position limits
	localparam logic [2:0] POS_PREFIX = 3'd3;
	localparam logic [2:0] POS_AFTER  = 3'd4;
	localparam logic [2:0] POS_SAT    = 3'd5;

	// Result slots and result candidates per input item
	localparam int RES_DEPTH = 3;
	localparam int CAND_NUM  = 4;

	typedef struct packed {
		logic [7:0] ch;
		logic       has;
		logic       last;
	} dsf_res_t;

endpackage

// File: hdl/dial_string_filter.sv
// Dial string filter: takes a command string one byte per item on s_axis (tlast on the
// final byte) and streams the filtered string on m_axis. Strings that do not open with
// ATD (any case), and strings of three bytes or fewer, pass unchanged. In an ATD string a
// leading ISDN 'I' is dropped, a single '+' is kept, only dial digits, A-C, '*', '#', '>'
// survive, and the I/i and G/g modifiers are moved to the end (before a final ';').
// Rate: one input item per cycle while m_axis_tready is high and no item yields more
// than one result; one register stage in, one result buffer out. An item yields zero to
// three results, sent one per cycle while m_axis_tready is high; the final byte may hold
// input until all but one are sent. A string yielding nothing ends in a tuser-0 result.
module dial_string_filter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tuser,   // out_has_byte
	output logic       m_axis_tlast    // out_last
);
	import dsf_pkg::*;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// String state
	logic [2:0] pos_q;
	logic       prefix_q;
	logic       isdn_q;
	logic       up_i_q;
	logic       lo_i_q;
	logic       g_q;

	// Result buffer
	dsf_res_t   res_q [RES_DEPTH];
	logic [1:0] cnt_q;

	// Next state and results
	logic [2:0] pos_nxt;
	logic       prefix_nxt;
	logic       isdn_nxt;
	logic       up_i_nxt;
	logic       lo_i_nxt;
	logic       g_nxt;
	logic       hit;
	logic       in_atd;
	logic       prim;
	logic       semi;
	logic [CAND_NUM-1:0] cand_v;
	dsf_res_t   cand [CAND_NUM];
	dsf_res_t   res_c [RES_DEPTH];
	logic [2:0] n_c;
	logic [2:0] n_m1;

	logic pop;
	logic move_s1;

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign move_s1       = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
	assign s_axis_tready = !valid_s1 || move_s1;

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = res_q[0].ch;
	assign m_axis_tuser  = res_q[0].has;
	assign m_axis_tlast  = res_q[0].last;

	// Hold the accepted item in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Filter one byte and build its result list
	always_comb begin
		pos_nxt    = pos_q;
		prefix_nxt = prefix_q;
		isdn_nxt   = isdn_q;
		up_i_nxt   = up_i_q;
		lo_i_nxt   = lo_i_q;
		g_nxt      = g_q;
		hit        = 1'b0;
		prim       = 1'b0;
		semi       = 1'b0;
		in_atd     = prefix_q && (pos_q >= POS_PREFIX);

		if (pos_q < POS_PREFIX) begin
			prim = 1'b1;
			case (pos_q)
				3'd0:    hit = (byte_s1 == CH_UP_A) || (byte_s1 == CH_LO_A);
				3'd1:    hit = (byte_s1 == CH_UP_T) || (byte_s1 == CH_LO_T);
				default: hit = (byte_s1 == CH_UP_D) || (byte_s1 == CH_LO_D);
			endcase
			prefix_nxt = (pos_q == 3'd0) ? hit : (prefix_q && hit);
		end else if (!prefix_q) begin
			prim = 1'b1;
		end else begin
			if ((pos_q == POS_PREFIX) && (byte_s1 == CH_UP_I)) begin
				isdn_nxt = 1'b1;
			end else if (((pos_q == POS_PREFIX) || ((pos_q == POS_AFTER) && isdn_q))
					&& (byte_s1 == CH_PLUS)) begin
				prim = 1'b1;
			end else if (byte_s1 == CH_UP_I) begin
				up_i_nxt = 1'b1;
				lo_i_nxt = 1'b0;
			end else if (byte_s1 == CH_LO_I) begin
				lo_i_nxt = 1'b1;
				up_i_nxt = 1'b0;
			end else if ((byte_s1 == CH_UP_G) || (byte_s1 == CH_LO_G)) begin
				g_nxt = 1'b1;
			end else if (byte_s1 inside {[CH_0:CH_9], [CH_LO_A:CH_LO_C], [CH_UP_A:CH_UP_C],
					CH_STAR, CH_HASH, CH_GT}) begin
				prim = 1'b1;
			end else if (last_s1 && (byte_s1 == CH_SEMI)) begin
				semi = 1'b1;
			end
		end

		// Candidates in output order: byte, modifier I, modifier G, final semicolon
		cand_v[0] = prim;
		cand[0]   = '{ch: byte_s1, has: 1'b1, last: 1'b0};
		cand_v[1] = last_s1 && in_atd && (up_i_nxt || lo_i_nxt);
		cand[1]   = '{ch: (up_i_nxt ? CH_UP_I : CH_LO_I), has: 1'b1, last: 1'b0};
		cand_v[2] = last_s1 && in_atd && g_nxt;
		cand[2]   = '{ch: CH_UP_G, has: 1'b1, last: 1'b0};
		cand_v[3] = semi;
		cand[3]   = '{ch: CH_SEMI, has: 1'b1, last: 1'b0};

		// Pack the candidates into the result slots
		for (int k = 0; k < RES_DEPTH; k++) begin
			res_c[k] = '{ch: 8'h00, has: 1'b0, last: 1'b0};
		end
		n_c = 3'd0;
		for (int k = 0; k < CAND_NUM; k++) begin
			if (cand_v[k] && (n_c < 3'(RES_DEPTH))) begin
				res_c[n_c[1:0]] = cand[k];
				n_c = n_c + 3'd1;
			end
		end

		// Close the string: empty marker if nothing else, last flag on the final slot
		if (last_s1 && (n_c == 3'd0)) begin
			n_c = 3'd1;
		end
		n_m1 = n_c - 3'd1;
		if (last_s1) begin
			res_c[n_m1[1:0]].last = 1'b1;
		end

		// Advance the position, clear everything at the end of a string
		if (pos_q < POS_SAT) begin
			pos_nxt = pos_q + 3'd1;
		end
		if (last_s1) begin
			pos_nxt    = 3'd0;
			prefix_nxt = 1'b0;
			isdn_nxt   = 1'b0;
			up_i_nxt   = 1'b0;
			lo_i_nxt   = 1'b0;
			g_nxt      = 1'b0;
		end
	end

	// Update the string state when an item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 3'd0;
			prefix_q <= 1'b0;
			isdn_q   <= 1'b0;
			up_i_q   <= 1'b0;
			lo_i_q   <= 1'b0;
			g_q      <= 1'b0;
		end else if (move_s1) begin
			pos_q    <= pos_nxt;
			prefix_q <= prefix_nxt;
			isdn_q   <= isdn_nxt;
			up_i_q   <= up_i_nxt;
			lo_i_q   <= lo_i_nxt;
			g_q      <= g_nxt;
		end
	end

	// Result count: load on a new item, count down on each send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (move_s1) begin
			cnt_q <= n_c[1:0];
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Result slots: load, or shift toward the output
	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_q <= res_c;
		end else if (pop) begin
			for (int k = 0; k < RES_DEPTH - 1; k++) begin
				res_q[k] <= res_q[k+1];
			end
		end
	end

`include "dial_string_filter_assert.svh"

	`DSF_ASSERT_SAME(a_empty_is_last, m_axis_tvalid && !m_axis_tuser, m_axis_tlast, "empty result not final")
	`DSF_ASSERT_SAME(a_last_only_final, cnt_q > 2'd1, !res_q[0].last, "last flag before final result")
	`DSF_ASSERT_NEXT(a_state_clear, move_s1 && last_s1, pos_q == 3'd0 && !g_q && !isdn_q, "state not cleared after string")
	`DSF_ASSERT_SAME(a_mod_after_prefix, pos_q <= POS_PREFIX, !up_i_q && !lo_i_q && !g_q, "modifier seen inside prefix")

endmodule
